// ----- hdl/hbs_pkg.sv -----
package hbs_pkg;

  localparam int unsigned MAX_MAP_WIDTH  = 256;
  localparam int unsigned MAX_MAP_HEIGHT = 256;
  localparam int unsigned HEIGHT_BITS    = 16;
  localparam int unsigned ADDR_BITS      = 16;
  localparam int unsigned DIM_BITS       = 9;
  localparam int unsigned SCALE_BITS     = 24;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned Q_PTR_BITS     = $clog2(Q_DEPTH);

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_INV_SCALE  = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                   rd;
    logic [ADDR_BITS-1:0]   a00;
    logic [ADDR_BITS-1:0]   a10;
    logic [ADDR_BITS-1:0]   a01;
    logic [ADDR_BITS-1:0]   a11;
    logic [FRAC_BITS-1:0]   fx;
    logic [FRAC_BITS-1:0]   fz;
    logic [HEIGHT_BITS-1:0] wdata;
  } q_item_t;

endpackage

// ----- hdl/hbs_front.sv -----
module hbs_front import hbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DIM_BITS-1:0]   width_i,
  input  logic [DIM_BITS-1:0]   height_i,
  input  logic [SCALE_BITS-1:0] inv_scale_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [ADDR_BITS-1:0]  map_index_i,
  input  logic [HEIGHT_BITS-1:0] height_in_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_z_i,
  output logic                  push_o,
  output q_item_t               item_o,
  input  logic                  full_i
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;
  logic c1_q, c2_q, c3_q;
  logic [ADDR_BITS-1:0] idx1_q, idx2_q, idx3_q;
  logic [HEIGHT_BITS-1:0] hgt1_q, hgt2_q, hgt3_q;
  logic signed [56:0] px_q, pz_q;
  logic signed [43:0] mx_q, mz_q;
  logic [23:0] cx_q, cz_q;
  q_item_t item_q;

  logic signed [33:0] ux, uz;
  logic signed [44:0] crx, crz, limx, limz;
  logic [23:0] cx_d, cz_d;
  logic [16:0] prod;
  logic [ADDR_BITS-1:0] a00;

  assign en         = !(v4_q && full_i);
  assign in_ready_o = en;
  assign push_o     = v4_q && !full_i;
  assign item_o     = item_q;

  assign ux = {px_q[56], px_q[56:24]} + 34'sd32768;
  assign uz = {pz_q[56], pz_q[56:24]} + 34'sd32768;

  assign crx  = {mx_q[43], mx_q} + 45'sd32768;
  assign crz  = {mz_q[43], mz_q} + 45'sd32768;
  assign limx = $signed({20'd0, width_i - 9'd1, 16'd0});
  assign limz = $signed({20'd0, height_i - 9'd1, 16'd0});

  always_comb begin
    if (crx >= limx) begin
      cx_d = {width_i[7:0] - 8'd2, 16'd0};
    end else if (crx[44]) begin
      cx_d = '0;
    end else begin
      cx_d = crx[23:0];
    end
    if (crz >= limz) begin
      cz_d = {height_i[7:0] - 8'd2, 16'd0};
    end else if (crz[44]) begin
      cz_d = '0;
    end else begin
      cz_d = crz[23:0];
    end
  end

  assign prod = cz_q[23:16] * width_i;
  assign a00  = ADDR_BITS'(prod + {9'd0, cx_q[23:16]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q   <= cmd_i;
      idx1_q <= map_index_i;
      hgt1_q <= height_in_i;
      px_q   <= pos_x_i * $signed({1'b0, inv_scale_i});
      pz_q   <= pos_z_i * $signed({1'b0, inv_scale_i});
      c2_q   <= c1_q;
      idx2_q <= idx1_q;
      hgt2_q <= hgt1_q;
      mx_q   <= ux * $signed({1'b0, width_i});
      mz_q   <= uz * $signed({1'b0, height_i});
      c3_q   <= c2_q;
      idx3_q <= idx2_q;
      hgt3_q <= hgt2_q;
      cx_q   <= cx_d;
      cz_q   <= cz_d;
      item_q.rd    <= (c3_q == CMD_SAMPLE);
      item_q.a00   <= (c3_q == CMD_SAMPLE) ? a00 : idx3_q;
      item_q.a10   <= a00 + 16'd1;
      item_q.a01   <= a00 + {7'd0, width_i};
      item_q.a11   <= a00 + {7'd0, width_i} + 16'd1;
      item_q.fx    <= cx_q[15:0];
      item_q.fz    <= cz_q[15:0];
      item_q.wdata <= hgt3_q;
    end
  end

endmodule

// ----- hdl/hbs_fifo.sv -----
module hbs_fifo import hbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_item_t data_o,
  output logic    empty_o
);

  q_item_t mem_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wp_q, rp_q;
  logic [Q_PTR_BITS:0]   cnt_q;

  assign full_o  = (cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Q_PTR_BITS+1)'(push_i) - (Q_PTR_BITS+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_PTR_BITS+1)'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- hdl/hbs_back.sv -----
module hbs_back import hbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  q_item_t                item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [HEIGHT_BITS-1:0] height_out_o
);

  logic [HEIGHT_BITS-1:0] mem0 [2**ADDR_BITS];
  logic [HEIGHT_BITS-1:0] mem1 [2**ADDR_BITS];
  logic [HEIGHT_BITS-1:0] mem2 [2**ADDR_BITS];
  logic [HEIGHT_BITS-1:0] mem3 [2**ADDR_BITS];

  logic en, wr;
  logic b1v_q, b2v_q, ov_q;
  logic [HEIGHT_BITS-1:0] v1_q, v2_q, v3_q, v4_q;
  logic [FRAC_BITS-1:0] fx1_q, fz1_q, fz2_q;
  logic [31:0] ha_q, hb_q;
  logic [HEIGHT_BITS-1:0] res_q;
  logic [16:0] wx0, wx1, wz0, wz1;
  logic [48:0] vsum;

  assign en          = !(ov_q && !out_ready_i);
  assign pop_o       = en && !empty_i;
  assign wr          = pop_o && !item_i.rd;
  assign out_valid_o = ov_q;
  assign height_out_o = res_q;

  assign wx1 = {1'b0, fx1_q};
  assign wx0 = 17'h10000 - wx1;
  assign wz1 = {1'b0, fz2_q};
  assign wz0 = 17'h10000 - wz1;
  assign vsum = 49'(ha_q * wz0) + 49'(hb_q * wz1);

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem0[item_i.a00] <= item_i.wdata;
      mem1[item_i.a00] <= item_i.wdata;
      mem2[item_i.a00] <= item_i.wdata;
      mem3[item_i.a00] <= item_i.wdata;
    end
    if (en) begin
      v1_q <= mem0[item_i.a00];
      v2_q <= mem1[item_i.a10];
      v3_q <= mem2[item_i.a01];
      v4_q <= mem3[item_i.a11];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1v_q <= 1'b0;
      b2v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else if (en) begin
      b1v_q <= pop_o && item_i.rd;
      b2v_q <= b1v_q;
      ov_q  <= b2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx1_q <= item_i.fx;
      fz1_q <= item_i.fz;
      ha_q  <= 32'(v1_q * wx0) + 32'(v2_q * wx1);
      hb_q  <= 32'(v3_q * wx0) + 32'(v4_q * wx1);
      fz2_q <= fz1_q;
      res_q <= vsum[47:32];
    end
  end

endmodule

// ----- hdl/heightmap_bilinear_sampler_top.sv -----
// Height map sampler.
// Input channel (in_valid_i/in_ready_o) carries one item per accept. cmd 0
// stores height_in_i at map_index_i and gives no result; cmd 1 samples the
// map at world position (pos_x_i, pos_z_i) and returns one height_out_o item
// on the output channel (out_valid_o/out_ready_i).
// Configuration writes (cfg_valid_i, always ready) set map width, map height
// and the inverse world scale; write them only while the block is idle.
// Throughput: one item per cycle while no stall holds the flow. A four-stage
// front end maps coordinates and addresses, a four-entry queue follows, and
// the back end reads four replicated height memories into registers, then
// interpolates along x into two registered sums and along z into the output register.
// A stalled receiver holds the output register; the back end stops, the
// queue fills, and then the front end drops in_ready_o.
// Reset clears pipeline and queue control and loads 256, 256, 16384 into the
// registers. Map contents are undefined until written; no clearing pass.
module heightmap_bilinear_sampler_top import hbs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [SCALE_BITS-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [ADDR_BITS-1:0]    map_index_i,
  input  logic [HEIGHT_BITS-1:0]  height_in_i,
  input  logic signed [31:0]      pos_x_i,
  input  logic signed [31:0]      pos_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [HEIGHT_BITS-1:0]  height_out_o
);

  logic [DIM_BITS-1:0] map_width_q, map_height_q, w_sat, h_sat;
  logic [SCALE_BITS-1:0] inv_scale_q;
  logic push, full, pop, empty;
  q_item_t f_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= DIM_BITS'(MAX_MAP_WIDTH);
      map_height_q <= DIM_BITS'(MAX_MAP_HEIGHT);
      inv_scale_q  <= SCALE_BITS'(16384);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i[DIM_BITS-1:0];
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i[DIM_BITS-1:0];
        CFG_INV_SCALE:  inv_scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_width_q < 9'd2) w_sat = 9'd2;
    else if (map_width_q > DIM_BITS'(MAX_MAP_WIDTH)) w_sat = DIM_BITS'(MAX_MAP_WIDTH);
    else w_sat = map_width_q;
    if (map_height_q < 9'd2) h_sat = 9'd2;
    else if (map_height_q > DIM_BITS'(MAX_MAP_HEIGHT)) h_sat = DIM_BITS'(MAX_MAP_HEIGHT);
    else h_sat = map_height_q;
  end

  hbs_front u_front (
    .clk_i, .rst_ni,
    .width_i(w_sat), .height_i(h_sat), .inv_scale_i(inv_scale_q),
    .in_valid_i, .in_ready_o,
    .cmd_i, .map_index_i, .height_in_i, .pos_x_i, .pos_z_i,
    .push_o(push), .item_o(f_item), .full_i(full)
  );

  hbs_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(f_item), .full_o(full),
    .pop_i(pop), .data_o(q_item), .empty_o(empty)
  );

  hbs_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .height_out_o
  );

endmodule

// ----- verif/heightmap_sampler_checker.sv -----
module heightmap_sampler_checker import hbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [SCALE_BITS-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   cmd_i,
  input  logic [ADDR_BITS-1:0]   map_index_i,
  input  logic [HEIGHT_BITS-1:0] height_in_i,
  input  logic signed [31:0]     pos_x_i,
  input  logic signed [31:0]     pos_z_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [HEIGHT_BITS-1:0] height_out_i,
  output int                     errors_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [HEIGHT_BITS-1:0] height_mem [1 << ADDR_BITS];
  logic [DIM_BITS-1:0]    width_q;
  logic [DIM_BITS-1:0]    depth_q;
  logic [SCALE_BITS-1:0]  scale_q;
  logic [HEIGHT_BITS-1:0] heights_due [$];

  function automatic longint sat_dim(logic [DIM_BITS-1:0] d, longint max_d);
    if (d < 2) return 2;
    if (longint'(d) > max_d) return max_d;
    return longint'(d);
  endfunction

  function automatic longint texel_q16(logic signed [31:0] pos, longint dim);
    longint p;
    longint c;
    p = longint'(pos) * longint'(scale_q);
    c = ((p >>> 24) + 32768) * dim + 32768;
    if (c >= ((dim - 1) <<< 16)) c = (dim - 2) <<< 16;
    if (c < 0) c = 0;
    return c;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] bilinear_height(logic signed [31:0] px,
                                                           logic signed [31:0] pz);
    longint w, h, cx, cz, ix, iz, fx, fz, a, b, r;
    logic [ADDR_BITS-1:0] a00, a10, a01, a11;
    w  = sat_dim(width_q, MAX_MAP_WIDTH);
    h  = sat_dim(depth_q, MAX_MAP_HEIGHT);
    cx = texel_q16(px, w);
    cz = texel_q16(pz, h);
    ix = cx >>> 16;
    iz = cz >>> 16;
    fx = cx & 16'hFFFF;
    fz = cz & 16'hFFFF;
    a00 = ADDR_BITS'(iz * w + ix);
    a10 = ADDR_BITS'(iz * w + ix + 1);
    a01 = ADDR_BITS'((iz + 1) * w + ix);
    a11 = ADDR_BITS'((iz + 1) * w + ix + 1);
    a = longint'(height_mem[a00]) * (65536 - fx) + longint'(height_mem[a10]) * fx;
    b = longint'(height_mem[a01]) * (65536 - fx) + longint'(height_mem[a11]) * fx;
    r = (a * (65536 - fz) + b * fz) >> 32;
    return HEIGHT_BITS'(r);
  endfunction

  assign pending_o = heights_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_BITS'(256);
      depth_q  <= DIM_BITS'(256);
      scale_q  <= SCALE_BITS'(16384);
      errors_o <= 0;
      heights_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAP_WIDTH:  width_q <= cfg_data_i[DIM_BITS-1:0];
          CFG_MAP_HEIGHT: depth_q <= cfg_data_i[DIM_BITS-1:0];
          CFG_INV_SCALE:  scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_WRITE) begin
          height_mem[map_index_i] = height_in_i;
        end else begin
          heights_due.push_back(bilinear_height(pos_x_i, pos_z_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (heights_due.size() == 0) begin
          $display("%t unexpected height_out: expected none, got %h", $time, height_out_i);
          errors_o <= errors_o + 1;
        end else begin
          if (heights_due[0] !== height_out_i) begin
            $display("%t height_out mismatch: expected %h, got %h", $time,
                     heights_due[0], height_out_i);
            errors_o <= errors_o + 1;
          end
          void'(heights_due.pop_front());
        end
      end
    end
  end
endmodule

// ----- verif/tb_heightmap_bilinear_sampler_top.sv -----
module tb_heightmap_bilinear_sampler_top import hbs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i = '0;
  logic [SCALE_BITS-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   cmd_i = CMD_WRITE;
  logic [ADDR_BITS-1:0]   map_index_i = '0;
  logic [HEIGHT_BITS-1:0] height_in_i = '0;
  logic signed [31:0]     pos_x_i = '0;
  logic signed [31:0]     pos_z_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [HEIGHT_BITS-1:0] height_out_o;
  int                     errors;
  int                     pending;

  bit                     filled [1 << ADDR_BITS];
  logic [DIM_BITS-1:0]    cur_width = DIM_BITS'(256);
  logic [DIM_BITS-1:0]    cur_depth = DIM_BITS'(256);
  logic [SCALE_BITS-1:0]  cur_scale = SCALE_BITS'(16384);
  bit                     no_gaps;
  bit                     long_hold_req;
  int                     n_writes;
  int                     n_samples;
  int                     n_phases;

  heightmap_bilinear_sampler_top dut (.*);

  heightmap_sampler_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .map_index_i, .height_in_i,
    .pos_x_i, .pos_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .height_out_i(height_out_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        out_ready_i <= (pick_gap() == 0);
        @(posedge clk_i);
      end
    end
  end

  function automatic longint lim_dim(logic [DIM_BITS-1:0] d, longint max_d);
    if (d < 2) return 2;
    if (longint'(d) > max_d) return max_d;
    return longint'(d);
  endfunction

  function automatic longint cell_q16(logic signed [31:0] pos, longint dim);
    longint c;
    c = (((longint'(pos) * longint'(cur_scale)) >>> 24) + 32768) * dim + 32768;
    if (c >= ((dim - 1) <<< 16)) c = (dim - 2) <<< 16;
    if (c < 0) c = 0;
    return c;
  endfunction

  task automatic send_item(logic cmd, logic [ADDR_BITS-1:0] idx, logic [HEIGHT_BITS-1:0] hgt,
                           logic signed [31:0] px, logic signed [31:0] pz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    map_index_i <= idx;
    height_in_i <= hgt;
    pos_x_i     <= px;
    pos_z_i     <= pz;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (cmd == CMD_WRITE) n_writes++;
    else n_samples++;
  endtask

  function automatic logic [HEIGHT_BITS-1:0] rand_height();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return HEIGHT_BITS'($urandom);
    endcase
  endfunction

  task automatic write_height(logic [ADDR_BITS-1:0] idx, logic [HEIGHT_BITS-1:0] hgt);
    send_item(CMD_WRITE, idx, hgt, 32'($urandom), 32'($urandom));
    filled[idx] = 1'b1;
  endtask

  // no sample may touch an entry never written
  task automatic sample_at(logic signed [31:0] px, logic signed [31:0] pz);
    longint w, h, ix, iz;
    logic [ADDR_BITS-1:0] a;
    w  = lim_dim(cur_width, MAX_MAP_WIDTH);
    h  = lim_dim(cur_depth, MAX_MAP_HEIGHT);
    ix = cell_q16(px, w) >>> 16;
    iz = cell_q16(pz, h) >>> 16;
    for (int k = 0; k < 4; k++) begin
      a = ADDR_BITS'((iz + k / 2) * w + ix + k % 2);
      if (!filled[a]) write_height(a, rand_height());
    end
    send_item(CMD_SAMPLE, ADDR_BITS'($urandom), HEIGHT_BITS'($urandom), px, pz);
  endtask

  function automatic logic signed [31:0] rand_pos();
    longint t, p;
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2, 3: return 32'($urandom);
      default: begin
        if (cur_scale == 0) return 32'($urandom);
        t = longint'($urandom_range(0, 80000)) - 40000;
        p = (t <<< 24) / longint'(cur_scale) + longint'($urandom_range(0, 7)) - 3;
        if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
        if (p < -64'sh8000_0000) p = -64'sh8000_0000;
        return 32'(p);
      end
    endcase
  endfunction

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [SCALE_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_map(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                         logic [SCALE_BITS-1:0] s);
    drain();
    write_reg(CFG_MAP_WIDTH, {15'($urandom_range(0, 32767)), w});
    write_reg(CFG_MAP_HEIGHT, {15'($urandom_range(0, 32767)), h});
    write_reg(CFG_INV_SCALE, s);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, SCALE_BITS'($urandom));
    cfg_valid_i <= 1'b0;
    cur_width = w;
    cur_depth = h;
    cur_scale = s;
    n_phases++;
  endtask

  initial begin
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic [SCALE_BITS-1:0] s;
    int budget;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    set_map(DIM_BITS'(3), DIM_BITS'(2), SCALE_BITS'(16384));
    for (int i = 0; i < 6; i++) write_height(ADDR_BITS'(i), (i % 2) ? '1 : '0);
    write_height('1, '1);
    sample_at(32'sh8000_0000, 32'sh8000_0000);
    sample_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    sample_at(32'sh0, 32'sh0);
    sample_at(32'sh0001_0000, 32'sh8000_0000);
    sample_at(32'sh7FFF_FFFF, 32'shFFFF_0000);
    set_map(DIM_BITS'(0), DIM_BITS'(1), SCALE_BITS'(0));
    sample_at(32'sh1234_5678, 32'sh8000_0000);
    sample_at(32'sh7FFF_FFFF, 32'sh0);
    set_map(DIM_BITS'(511), DIM_BITS'(300), SCALE_BITS'(24'hFF_FFFF));
    sample_at(32'sh0, 32'sh0);
    sample_at(32'sh0000_8000, 32'shFFFF_8000);
    set_map(DIM_BITS'(256), DIM_BITS'(256), SCALE_BITS'(1));
    sample_at(32'sh7FFF_FFFF, 32'sh8000_0000);

    // random
    budget = 1400;
    while (budget > 0) begin
      case ($urandom_range(0, 7))
        0: begin w = DIM_BITS'($urandom); h = DIM_BITS'($urandom); end
        1: begin w = DIM_BITS'(256); h = DIM_BITS'(2); end
        default: begin
          w = DIM_BITS'($urandom_range(2, 12));
          h = DIM_BITS'($urandom_range(2, 12));
        end
      endcase
      case ($urandom_range(0, 7))
        0: s = '1;
        1: s = '0;
        2: s = SCALE_BITS'($urandom_range(1, 4));
        default: s = SCALE_BITS'($urandom_range(1024, 1 << 20));
      endcase
      set_map(w, h, s);
      // in the first random phase, hold the receiver off while it keeps sending
      if (budget == 1400) long_hold_req = 1'b1;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100 && budget > 0; i++, budget--) begin
        if ($urandom_range(0, 4) == 0)
          write_height(ADDR_BITS'($urandom_range(0, (w < 16 ? 16 : w) * 16)), rand_height());
        else if ($urandom_range(0, 40) == 0)
          write_height(ADDR_BITS'($urandom), rand_height());
        else
          sample_at(rand_pos(), rand_pos());
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d map writes and %0d height samples over %0d map settings,",
             n_writes, n_samples, n_phases);
    $display("including edge clamps, zero scale, out-of-range sizes and a long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/hbs_pkg.sv
hdl/hbs_front.sv
hdl/hbs_fifo.sv
hdl/hbs_back.sv
hdl/heightmap_bilinear_sampler_top.sv
verif/heightmap_sampler_checker.sv
verif/tb_heightmap_bilinear_sampler_top.sv
